// ===== rtl/core/positional_list_store_core_macros.svh =====
// Assertion macros used by the positional list store RTL.
`ifndef POSITIONAL_LIST_STORE_CORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_CORE_MACROS_SVH

// Checks that nxt holds in the cycle after cond, outside reset.
`define PLS_ASSERT_NEXT(label, cond, nxt) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
    else $error("assertion failed: next-cycle check");

// Checks that cond implies rule in the same cycle, outside reset.
`define PLS_ASSERT_NOW(label, cond, rule) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (rule)) \
    else $error("assertion failed: same-cycle check");

`endif

// ===== rtl/core/pls_pkg.sv =====
// Types, constants and codes of the positional list store.
package pls_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int POS_W     = 5;
  localparam int CNT_OUT_W = 5;
  localparam int CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [3:0] OP_APPEND      = 4'd0;
  localparam logic [3:0] OP_PREPEND     = 4'd1;
  localparam logic [3:0] OP_INSERT      = 4'd2;
  localparam logic [3:0] OP_TAKE_FRONT  = 4'd3;
  localparam logic [3:0] OP_TAKE_BACK   = 4'd4;
  localparam logic [3:0] OP_ERASE       = 4'd5;
  localparam logic [3:0] OP_ERASE_AFTER = 4'd6;
  localparam logic [3:0] OP_CLEAR       = 4'd7;
  localparam logic [3:0] OP_QUERY       = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [3:0]         op;
    logic [POS_W-1:0]   position;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [31:0]   removed_value;
    logic signed [31:0]   front_value;
    logic signed [31:0]   back_value;
    logic [CNT_OUT_W-1:0] element_count;
    logic                 is_empty;
  } rsp_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic               open;
    logic               close;
    logic [IDX_W-1:0]   at;
    logic signed [31:0] value;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/pls_cell.sv =====
// One storage cell of the list row: holds, takes from a neighbor, or loads.
module pls_cell (
  input  logic                     clk,
  input  logic [pls_pkg::IDX_W-1:0] index,
  input  pls_pkg::cell_ctrl_t      ctrl,
  input  logic signed [31:0]       left,
  input  logic signed [31:0]       right,
  input  logic [pls_pkg::IDX_W-1:0] sel,
  output logic signed [31:0]       value,
  output logic signed [31:0]       tap
);

  always_ff @(posedge clk) begin
    if (ctrl.open) begin
      if (index == ctrl.at) begin
        value <= ctrl.value;
      end else if (index > ctrl.at) begin
        value <= left;
      end
    end else if (ctrl.close) begin
      if (index >= ctrl.at) begin
        value <= right;
      end
    end
  end

  assign tap = (index == sel) ? value : 32'sd0;

endmodule

// ===== rtl/core/pls_chain.sv =====
// Row of list cells with neighbor links and a shared read-out tap.
module pls_chain (
  input  logic                      clk,
  input  pls_pkg::cell_ctrl_t       ctrl,
  input  logic [pls_pkg::IDX_W-1:0] sel,
  output logic signed [31:0]        front,
  output logic signed [31:0]        picked
);

  logic signed [31:0] vals [pls_pkg::DEPTH];
  logic signed [31:0] taps [pls_pkg::DEPTH];

  genvar g;
  generate
    for (g = 0; g < pls_pkg::DEPTH; g++) begin : g_cell
      logic signed [31:0] left_v;
      logic signed [31:0] right_v;
      if (g == 0) begin : g_first
        assign left_v = 32'sd0;
      end else begin : g_mid_l
        assign left_v = vals[g-1];
      end
      if (g == pls_pkg::DEPTH - 1) begin : g_last
        assign right_v = 32'sd0;
      end else begin : g_mid_r
        assign right_v = vals[g+1];
      end
      pls_cell u_cell (
        .clk   (clk),
        .index (pls_pkg::IDX_W'(g)),
        .ctrl  (ctrl),
        .left  (left_v),
        .right (right_v),
        .sel   (sel),
        .value (vals[g]),
        .tap   (taps[g])
      );
    end
  endgenerate

  assign front = vals[0];

  // Only the selected cell drives a nonzero tap, so an OR merges them.
  always_comb begin
    picked = 32'sd0;
    for (int i = 0; i < pls_pkg::DEPTH; i++) begin
      picked = picked | taps[i];
    end
  end

endmodule

// ===== rtl/core/positional_list_store_core.sv =====
// Top level of the positional list store: control, fill count and result register.
//
// A bounded ordered list of signed 32-bit values kept in a row of cells.
// Requests arrive on req (op, position, item_value) with req_valid/req_ready
// and each one yields exactly one result on rsp with rsp_valid/rsp_ready.
// The result carries the status, the removed value and the list as it
// stands afterwards: front, back, count and an empty flag.
// A request goes through an accept step, then an execute step in which every
// cell shifts or holds at once, then a load step that reads the new back cell
// through the row's shared tap and loads the result register. A new request
// is taken only after the previous one has loaded its result.
// The result register parts the two sides: a request is accepted while an
// earlier result still waits, and if the receiver stalls the block holds
// in its final step until the result register frees up.
// Reset empties the list at once; cell contents need no clearing because
// only cells below the count are ever read.
`include "positional_list_store_core_macros.svh"

module positional_list_store_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pls_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pls_pkg::rsp_t rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0]                state;
  pls_pkg::req_t             req_q;
  logic [pls_pkg::CNT_W-1:0] count;
  logic [pls_pkg::CNT_W-1:0] count_next;
  logic [1:0]                status_q;
  logic [1:0]                status_next;
  logic signed [31:0]        removed_q;
  pls_pkg::cell_ctrl_t       ctrl;
  logic [pls_pkg::IDX_W-1:0] sel;
  logic signed [31:0]        front;
  logic signed [31:0]        picked;
  logic [pls_pkg::CMP_W-1:0] pos_x;
  logic [pls_pkg::CMP_W-1:0] cnt_x;
  logic                      full;
  logic                      empty;
  logic                      rsp_free;

  assign req_ready = (state == S_IDLE);
  assign rsp_free  = !rsp_valid || rsp_ready;

  assign pos_x = pls_pkg::CMP_W'(req_q.position);
  assign cnt_x = pls_pkg::CMP_W'(count);
  assign full  = (cnt_x == pls_pkg::CMP_W'(pls_pkg::DEPTH));
  assign empty = (count == '0);

  always_comb begin
    ctrl.open   = 1'b0;
    ctrl.close  = 1'b0;
    ctrl.at     = '0;
    ctrl.value  = req_q.item_value;
    status_next = pls_pkg::ST_OK;
    count_next  = count;
    case (req_q.op)
      pls_pkg::OP_APPEND: begin
        if (full) begin
          status_next = pls_pkg::ST_FULL;
        end else begin
          ctrl.open = 1'b1;
          ctrl.at   = pls_pkg::IDX_W'(count);
        end
      end
      pls_pkg::OP_PREPEND: begin
        if (full) begin
          status_next = pls_pkg::ST_FULL;
        end else begin
          ctrl.open = 1'b1;
        end
      end
      pls_pkg::OP_INSERT: begin
        if (pos_x > cnt_x) begin
          status_next = pls_pkg::ST_RANGE;
        end else if (full) begin
          status_next = pls_pkg::ST_FULL;
        end else begin
          ctrl.open = 1'b1;
          ctrl.at   = pls_pkg::IDX_W'(req_q.position);
        end
      end
      pls_pkg::OP_TAKE_FRONT: begin
        if (empty) begin
          status_next = pls_pkg::ST_EMPTY;
        end else begin
          ctrl.close = 1'b1;
        end
      end
      pls_pkg::OP_TAKE_BACK: begin
        if (empty) begin
          status_next = pls_pkg::ST_EMPTY;
        end else begin
          ctrl.close = 1'b1;
          ctrl.at    = pls_pkg::IDX_W'(count - 1'b1);
        end
      end
      pls_pkg::OP_ERASE: begin
        if (pos_x >= cnt_x) begin
          status_next = pls_pkg::ST_RANGE;
        end else begin
          ctrl.close = 1'b1;
          ctrl.at    = pls_pkg::IDX_W'(req_q.position);
        end
      end
      pls_pkg::OP_ERASE_AFTER: begin
        if (pos_x + 1'b1 >= cnt_x) begin
          status_next = pls_pkg::ST_RANGE;
        end else begin
          ctrl.close = 1'b1;
          ctrl.at    = pls_pkg::IDX_W'(pos_x + 1'b1);
        end
      end
      pls_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
    if (ctrl.open) begin
      count_next = count + 1'b1;
    end else if (ctrl.close) begin
      count_next = count - 1'b1;
    end
    // The row only moves in the execute step.
    if (state != S_EXEC) begin
      ctrl.open  = 1'b0;
      ctrl.close = 1'b0;
    end
  end

  // The tap reads the cell being removed, then the new back cell.
  assign sel = (state == S_EXEC) ? ctrl.at : pls_pkg::IDX_W'(count - 1'b1);

  pls_chain u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .sel    (sel),
    .front  (front),
    .picked (picked)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_LOAD && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          count <= count_next;
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
    if (state == S_EXEC) begin
      status_q  <= status_next;
      removed_q <= ctrl.close ? picked : 32'sd0;
    end
    if (state == S_LOAD && rsp_free) begin
      rsp.status        <= status_q;
      rsp.removed_value <= removed_q;
      rsp.front_value   <= empty ? 32'sd0 : front;
      rsp.back_value    <= empty ? 32'sd0 : picked;
      rsp.element_count <= pls_pkg::CNT_OUT_W'(count);
      rsp.is_empty      <= empty;
    end
  end

  `PLS_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
  `PLS_ASSERT_NEXT(a_error_keeps_count, state == S_EXEC && status_next != pls_pkg::ST_OK,
                   count == $past(count))
  `PLS_ASSERT_NOW(a_count_bounded, state == S_LOAD,
                  pls_pkg::CMP_W'(count) <= pls_pkg::CMP_W'(pls_pkg::DEPTH))

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for positional_list_store_core with a list predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int CHUNK_ITEMS = 23;
  localparam int CHUNKS_PER_PHASE = 7;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  pls_pkg::req_t  req = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  pls_pkg::rsp_t  rsp;

  pls_pkg::req_t      pending_reqs[$];
  pls_pkg::rsp_t      expected_rsps[$];
  logic signed [31:0] shadow_list[$];

  logic req_accepted = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_trig = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   error_count = 0;
  int   rsp_index = 0;

  positional_list_store_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Applies one request to the shadow list and returns the result it should give.
  function automatic pls_pkg::rsp_t list_step(pls_pkg::req_t r);
    pls_pkg::rsp_t res;
    int            fill;
    int            pos;
    res = '0;
    fill = shadow_list.size();
    pos = r.position;
    res.status = pls_pkg::ST_OK;
    case (r.op)
      pls_pkg::OP_APPEND: begin
        if (fill >= pls_pkg::DEPTH) res.status = pls_pkg::ST_FULL;
        else shadow_list.insert(fill, r.item_value);
      end
      pls_pkg::OP_PREPEND: begin
        if (fill >= pls_pkg::DEPTH) res.status = pls_pkg::ST_FULL;
        else shadow_list.insert(0, r.item_value);
      end
      pls_pkg::OP_INSERT: begin
        // The range check wins over the full check.
        if (pos > fill) res.status = pls_pkg::ST_RANGE;
        else if (fill >= pls_pkg::DEPTH) res.status = pls_pkg::ST_FULL;
        else shadow_list.insert(pos, r.item_value);
      end
      pls_pkg::OP_TAKE_FRONT: begin
        if (fill == 0) res.status = pls_pkg::ST_EMPTY;
        else begin
          res.removed_value = shadow_list[0];
          shadow_list.delete(0);
        end
      end
      pls_pkg::OP_TAKE_BACK: begin
        if (fill == 0) res.status = pls_pkg::ST_EMPTY;
        else begin
          res.removed_value = shadow_list[fill - 1];
          shadow_list.delete(fill - 1);
        end
      end
      pls_pkg::OP_ERASE: begin
        if (pos >= fill) res.status = pls_pkg::ST_RANGE;
        else begin
          res.removed_value = shadow_list[pos];
          shadow_list.delete(pos);
        end
      end
      pls_pkg::OP_ERASE_AFTER: begin
        if (pos + 1 >= fill) res.status = pls_pkg::ST_RANGE;
        else begin
          res.removed_value = shadow_list[pos + 1];
          shadow_list.delete(pos + 1);
        end
      end
      pls_pkg::OP_CLEAR: shadow_list.delete();
      default: ;
    endcase
    fill = shadow_list.size();
    if (fill > 0) begin
      res.front_value = shadow_list[0];
      res.back_value = shadow_list[fill - 1];
    end
    res.element_count = fill[pls_pkg::CNT_OUT_W-1:0];
    res.is_empty = (fill == 0);
    return res;
  endfunction

  task automatic log_error(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want)
      log_error($sformatf("result %0d %s: expected %0h, got %0h", rsp_index, field, want, got));
  endtask

  task automatic check_result(pls_pkg::rsp_t got);
    pls_pkg::rsp_t want;
    if (expected_rsps.size() == 0) begin
      log_error($sformatf("result %0d arrived with no request outstanding", rsp_index));
    end else begin
      want = expected_rsps[0];
      expected_rsps.delete(0);
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("removed_value", want.removed_value, got.removed_value);
      check_field("front_value", want.front_value, got.front_value);
      check_field("back_value", want.back_value, got.back_value);
      check_field("element_count", 32'(want.element_count), 32'(got.element_count));
      check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
    end
    rsp_index++;
  endtask

  // Monitor: checks results and predicts each accepted request.
  always @(posedge clk) begin
    if (rst) begin
      shadow_list.delete();
      req_accepted <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      req_accepted <= req_valid && req_ready;
      if (rsp_valid && rsp_ready) check_result(rsp);
      if (req_valid && req_ready) expected_rsps.insert(expected_rsps.size(), list_step(req));
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Driver: presents pending requests, idling at random between them.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_accepted) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req <= pending_reqs[0];
        pending_reqs.delete(0);
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_seen != hold_trig) begin
      hold_seen <= hold_trig;
      hold_left <= HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_req(logic [3:0] op, int pos, logic [31:0] val);
    pls_pkg::req_t r;
    r.op = op;
    r.position = pos[pls_pkg::POS_W-1:0];
    r.item_value = val;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(19))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Random request; grow_pct sets how often an adding operation is chosen.
  task automatic add_random_req(int grow_pct);
    int         pick;
    int         pos;
    logic [3:0] op;
    pick = $urandom_range(99);
    if (pick < 2) op = pls_pkg::OP_CLEAR;
    else if (pick < 5) op = pls_pkg::OP_QUERY;
    else if (pick < 8) op = 4'($urandom_range(9, 15));
    else if ($urandom_range(99) < grow_pct) begin
      case ($urandom_range(2))
        0: op = pls_pkg::OP_APPEND;
        1: op = pls_pkg::OP_PREPEND;
        default: op = pls_pkg::OP_INSERT;
      endcase
    end else begin
      case ($urandom_range(3))
        0: op = pls_pkg::OP_TAKE_FRONT;
        1: op = pls_pkg::OP_TAKE_BACK;
        2: op = pls_pkg::OP_ERASE;
        default: op = pls_pkg::OP_ERASE_AFTER;
      endcase
    end
    pick = $urandom_range(99);
    if (pick < 50) pos = $urandom_range(0, 3);
    else if (pick < 85) pos = $urandom_range(0, pls_pkg::DEPTH);
    else pos = $urandom_range(0, 31);
    add_req(op, pos, pick_value());
  endtask

  // Waits until every request has been sent and every result has come back.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int idle_cfg[4][2];
    idle_cfg = '{'{0, 0}, '{88, 0}, '{0, 88}, '{31, 31}};
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    #1;

    // Empty list: every removal fails, insert past the end fails.
    add_req(pls_pkg::OP_QUERY, 0, 32'h0);
    add_req(pls_pkg::OP_TAKE_FRONT, 0, 32'h0);
    add_req(pls_pkg::OP_TAKE_BACK, 0, 32'h0);
    add_req(pls_pkg::OP_ERASE, 0, 32'h0);
    add_req(pls_pkg::OP_ERASE_AFTER, 0, 32'h0);
    add_req(pls_pkg::OP_INSERT, 1, 32'h1234_5678);
    // Fill to capacity with extreme and ordinary values.
    for (int i = 0; i < pls_pkg::DEPTH; i++) begin
      case (i % 3)
        0: add_req(pls_pkg::OP_APPEND, 0, (i == 0) ? 32'h8000_0000 : 32'(i));
        1: add_req(pls_pkg::OP_PREPEND, 0, (i == 1) ? 32'h7fff_ffff : 32'hffff_ffff);
        default: add_req(pls_pkg::OP_INSERT, i / 2, (i == 2) ? 32'h0 : 32'hdead_beef);
      endcase
    end
    add_req(pls_pkg::OP_APPEND, 0, 32'h1);
    add_req(pls_pkg::OP_PREPEND, 0, 32'h2);
    add_req(pls_pkg::OP_INSERT, pls_pkg::DEPTH, 32'h3);
    add_req(pls_pkg::OP_INSERT, pls_pkg::DEPTH + 1, 32'h4);
    add_req(pls_pkg::OP_ERASE, pls_pkg::DEPTH, 32'h0);
    add_req(pls_pkg::OP_ERASE, pls_pkg::DEPTH - 1, 32'h0);
    add_req(pls_pkg::OP_ERASE_AFTER, pls_pkg::DEPTH - 2, 32'h0);
    add_req(pls_pkg::OP_ERASE_AFTER, pls_pkg::DEPTH - 3, 32'h0);
    add_req(pls_pkg::OP_ERASE, 31, 32'h0);
    add_req(pls_pkg::OP_TAKE_BACK, 0, 32'h0);
    add_req(pls_pkg::OP_TAKE_FRONT, 0, 32'h0);
    add_req(4'd15, 31, 32'hffff_ffff);
    add_req(pls_pkg::OP_CLEAR, 0, 32'h0);
    add_req(pls_pkg::OP_QUERY, 0, 32'h0);
    wait_drained();

    foreach (idle_cfg[p]) begin
      send_idle_pct = idle_cfg[p][0];
      recv_stall_pct = idle_cfg[p][1];
      for (int c = 0; c < CHUNKS_PER_PHASE; c++)
        for (int k = 0; k < CHUNK_ITEMS; k++)
          add_random_req((c % 2 == 0) ? 80 : 25);
      wait_drained();

      if (p == 0) begin
        // Long receiver hold-off while the sender keeps offering requests.
        hold_trig++;
        for (int k = 0; k < 30; k++) add_random_req(70);
        while (hold_seen != hold_trig || hold_left != 0) begin
          @(posedge clk);
          #1;
        end
        wait_drained();
      end
    end

    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    #1;
    if (expected_rsps.size() != 0)
      log_error($sformatf("%0d results never arrived", expected_rsps.size()));
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
